### design/pid_speed_controller_top_defines.svh
// Assertion macros for the PID speed controller.
// Used by pid_speed_controller_top; relies on clk and rst_n in scope.
`ifndef PID_SPEED_CONTROLLER_TOP_DEFINES_SVH
`define PID_SPEED_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PSC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psc assertion failed");

// Next-cycle implication, checked out of reset
`define PSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psc assertion failed");

`endif

### design/psc_pkg.sv
// Shared types, constants and Q16.16 helpers for the PID speed controller.
// No dependencies.
package psc_pkg;

    // Q16.16 constants
    localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
    localparam logic signed [31:0] NEG_ONE_Q16 = -32'sd65536;
    localparam logic signed [31:0] DECAY_Q16   = 32'sd58982;   // 0.9, truncated
    localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;

    // Register reset values
    localparam logic [30:0]        RST_GAIN_P    = 31'd655360;
    localparam logic [30:0]        RST_GAIN_I    = 31'd0;
    localparam logic [30:0]        RST_GAIN_D    = 31'd0;
    localparam logic [30:0]        RST_INT_LIMIT = 31'd6553600;
    localparam logic [30:0]        RST_SLOPE_LIM = 31'd1310720;
    localparam logic signed [31:0] RST_CEILING   = 32'sd9830400;
    localparam logic signed [31:0] RST_FLOOR     = 32'sd0;

    // Register indexes; index 7 is unused
    typedef enum logic [2:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_SLOPE_LIMIT    = 3'd4,
        REG_OUTPUT_CEILING = 3'd5,
        REG_OUTPUT_FLOOR   = 3'd6
    } psc_reg_idx_t;

    // Configuration bundle
    typedef struct packed {
        logic [30:0]        gain_p;
        logic [30:0]        gain_i;
        logic [30:0]        gain_d;
        logic [30:0]        integral_limit;
        logic [30:0]        slope_limit;
        logic signed [31:0] output_ceiling;
        logic signed [31:0] output_floor;
    } psc_cfg_t;

    // Controller state carried from item to item
    typedef struct packed {
        logic signed [31:0] integral;
        logic signed [31:0] prev_error;
    } psc_state_t;

    // Sign-extend a 32-bit value to 34 bits
    function automatic logic signed [33:0] sext34(input logic signed [31:0] a);
        sext34 = {{2{a[31]}}, a};
    endfunction

    // Saturate a 34-bit sum to 32 signed bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v[33:31] == {3{v[33]}})
            sat34 = v[31:0];
        else if (v[33])
            sat34 = S32_MIN;
        else
            sat34 = S32_MAX;
    endfunction

    // Q16.16 product: floor(a*b / 2^16), saturated to 32 signed bits
    function automatic logic signed [31:0] mul_q16(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] prod;
        logic signed [63:0] shifted;
        prod    = a * b;
        shifted = prod >>> 16;
        if (shifted[63:31] == {33{shifted[63]}})
            mul_q16 = shifted[31:0];
        else if (shifted[63])
            mul_q16 = S32_MIN;
        else
            mul_q16 = S32_MAX;
    endfunction

endpackage

### design/psc_regs.sv
// Configuration register file for the PID speed controller.
// Depends on psc_pkg.
module psc_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output psc_pkg::psc_cfg_t   cfg
);

    psc_pkg::psc_cfg_t cfg_reg;

    // Register writes; bits above a register's width are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= psc_pkg::RST_GAIN_P;
            cfg_reg.gain_i         <= psc_pkg::RST_GAIN_I;
            cfg_reg.gain_d         <= psc_pkg::RST_GAIN_D;
            cfg_reg.integral_limit <= psc_pkg::RST_INT_LIMIT;
            cfg_reg.slope_limit    <= psc_pkg::RST_SLOPE_LIM;
            cfg_reg.output_ceiling <= psc_pkg::RST_CEILING;
            cfg_reg.output_floor   <= psc_pkg::RST_FLOOR;
        end
        else if (cfg_write)
        begin
            unique case (psc_pkg::psc_reg_idx_t'(cfg_index))
                psc_pkg::REG_GAIN_P:         cfg_reg.gain_p         <= cfg_data[30:0];
                psc_pkg::REG_GAIN_I:         cfg_reg.gain_i         <= cfg_data[30:0];
                psc_pkg::REG_GAIN_D:         cfg_reg.gain_d         <= cfg_data[30:0];
                psc_pkg::REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_data[30:0];
                psc_pkg::REG_SLOPE_LIMIT:    cfg_reg.slope_limit    <= cfg_data[30:0];
                psc_pkg::REG_OUTPUT_CEILING: cfg_reg.output_ceiling <= cfg_data;
                psc_pkg::REG_OUTPUT_FLOOR:   cfg_reg.output_floor   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/psc_datapath.sv
// Single-pass PID arithmetic: error, integral with anti-windup, slope-limited
// derivative and clamped output. Depends on psc_pkg.
module psc_datapath
(
    input  logic signed [31:0]  measured,
    input  logic signed [31:0]  setpoint,
    input  psc_pkg::psc_state_t state,
    input  psc_pkg::psc_cfg_t   cfg,
    output psc_pkg::psc_state_t state_next,
    output logic signed [31:0]  drive
);

    // Symmetric clamp to +-lim
    function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] v,
                                                     input logic [30:0] lim);
        logic signed [32:0] v33;
        logic signed [32:0] pos33;
        logic signed [32:0] neg33;
        v33   = {v[31], v};
        pos33 = {2'b00, lim};
        neg33 = -pos33;
        if (v33 > pos33)
            clamp_sym = pos33[31:0];
        else if (v33 < neg33)
            clamp_sym = neg33[31:0];
        else
            clamp_sym = v;
    endfunction

    logic signed [31:0] err;
    logic               opposite;
    logic signed [31:0] acc_cleared;
    logic signed [31:0] acc_decayed;
    logic signed [31:0] i_incr;
    logic signed [31:0] acc_sum;
    logic signed [31:0] acc_final;
    logic signed [31:0] diff;
    logic signed [31:0] diff_lim;
    logic signed [31:0] p_term;
    logic signed [31:0] d_term;
    logic signed [31:0] total;

    // Error
    assign err = psc_pkg::sat34(psc_pkg::sext34(setpoint) - psc_pkg::sext34(measured));

    // Integral: clear on opposite direction, decay on zero measurement, add Ki*e, clamp to +-limit
    assign opposite = (setpoint > 32'sd0 && measured < psc_pkg::NEG_ONE_Q16) ||
                      (setpoint < 32'sd0 && measured > psc_pkg::ONE_Q16);
    assign acc_cleared = opposite ? 32'sd0 : state.integral;
    assign acc_decayed = (measured == 32'sd0) ?
                         psc_pkg::mul_q16(acc_cleared, psc_pkg::DECAY_Q16) : acc_cleared;
    assign i_incr    = psc_pkg::mul_q16(err, $signed({1'b0, cfg.gain_i}));
    assign acc_sum   = psc_pkg::sat34(psc_pkg::sext34(acc_decayed) + psc_pkg::sext34(i_incr));
    assign acc_final = clamp_sym(acc_sum, cfg.integral_limit);

    // Derivative on the slope-limited error difference
    assign diff     = psc_pkg::sat34(psc_pkg::sext34(err) - psc_pkg::sext34(state.prev_error));
    assign diff_lim = clamp_sym(diff, cfg.slope_limit);
    assign d_term   = psc_pkg::mul_q16(diff_lim, $signed({1'b0, cfg.gain_d}));

    // Proportional
    assign p_term = psc_pkg::mul_q16($signed({1'b0, cfg.gain_p}), err);

    // Sum and output clamp, ceiling checked first
    assign total = psc_pkg::sat34(psc_pkg::sext34(p_term) + psc_pkg::sext34(acc_final) +
                                  psc_pkg::sext34(d_term));

    always_comb
    begin
        if (total > cfg.output_ceiling)
            drive = cfg.output_ceiling;
        else if (total < cfg.output_floor)
            drive = cfg.output_floor;
        else
            drive = total;
    end

    assign state_next.integral   = acc_final;
    assign state_next.prev_error = err;

endmodule

### design/pid_speed_controller_top.sv
// Usage notes for the PID speed controller.
//
// Input channel: in_valid / in_stall with measured and setpoint (signed
// Q16.16). A transfer happens on a rising edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall with drive; every
// input transfer yields exactly one drive, in order.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// per edge (gains, integral and slope limits, output ceiling and floor).
// Index 7 is ignored. Write only while no item is in flight.
// Data path: an item sits in the input register, the whole PID update runs
// combinationally from there into the result register, which offers drive.
// Throughput: one item per cycle while out_stall is low; the integral and
// last-error update loop, closed through the state register, is what sets
// that figure.
// Stall: while out_stall holds a waiting result, one more item is taken into
// the input register, then in_stall rises until the result is taken.
// Reset: rst_n (async, active low) empties both registers, zeroes the
// integral and last error, and loads the register defaults.
//
// Depends on psc_pkg, psc_regs, psc_datapath and the defines header.
`include "pid_speed_controller_top_defines.svh"

module pid_speed_controller_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] measured,
    input  logic signed [31:0] setpoint,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] drive,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    psc_pkg::psc_cfg_t   cfg;
    psc_pkg::psc_state_t state_reg;
    psc_pkg::psc_state_t state_next;

    logic               in_valid_reg;
    logic signed [31:0] measured_reg;
    logic signed [31:0] setpoint_reg;
    logic               out_valid_reg;
    logic signed [31:0] drive_reg;
    logic signed [31:0] drive_next;
    logic               out_free;
    logic               move;
    logic               take;

    // Configuration registers
    psc_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // PID arithmetic
    psc_datapath u_datapath
    (
        .measured   (measured_reg),
        .setpoint   (setpoint_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .drive      (drive_next)
    );

    // Handshake: input register advances when the result register can load
    assign out_free = !out_valid_reg || !out_stall;
    assign move     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign take     = in_valid && !in_stall;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (move)
                in_valid_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (move)
                state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            measured_reg <= measured;
            setpoint_reg <= setpoint;
        end
        if (move)
            drive_reg <= drive_next;
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // Checks
    `PSC_ASSERT_IMPLY(a_stall_cause, in_stall, in_valid_reg && out_valid_reg && out_stall)
    `PSC_ASSERT_NEXT(a_move_loads_out, move, out_valid_reg)
    `PSC_ASSERT_NEXT(a_state_holds, !move, $stable(state_reg))

endmodule
